// ===== design/pida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and codes for the positional insert/delete array list.
// ----------------------------------------------------------------------------
package pida_pkg;

    localparam int POS_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int MAX_RESULTS = 64;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op     op;
        logic    load_out;
        t_status status;
        logic    last;
        logic    from_head;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

// ===== design/positional_insert_delete_array_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array_top
// Fixed-capacity ordered list of signed words with append, positional
// insert and delete, and full read-out.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with i_command, i_position, i_element;
//   an item is taken at a clock edge with i_valid high and o_stall low.
//   output channel: o_valid / i_stall with o_status, o_value, o_last, o_count.
//   append, insert and delete complete when the item is taken: the entries sit in a
//   register chain that shifts every entry at once, and the single result
//   shows in the output register the cycle after the item is taken.
//   one such item can be taken every cycle while results are drained.
//   read-out rotates the chain one entry per cycle while no held result
//   stalls it, emitting the head each step; the read state loads the first
//   result into the output register, the input stays stalled until the
//   read-out ends, min(count, 64) results come out and the order is unchanged.
//   an empty read-out gives one result with status empty the next cycle.
//   when i_stall holds a result, the chain and the input wait with it.
//   reset clears the count and the output valid; entry contents are not
//   cleared and are only read after being written.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_command,
    input  logic [pida_pkg::POS_W-1:0]           i_position,
    input  logic signed [pida_pkg::VALUE_W-1:0]  i_element,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_status,
    output logic signed [pida_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_last,
    output logic [pida_pkg::COUNT_W-1:0]         o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    pida_pkg::t_dp_cmd  w_cmd;
    pida_pkg::t_dp_stat w_stat;
    pida_pkg::t_status  w_status;
    logic [CW-1:0]      w_used;

    pida_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_position (i_position),
        .i_stall    (i_stall),
        .i_stat     (w_stat),
        .i_used     (w_used),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_cmd      (w_cmd)
    );

    pida_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_position (i_position),
        .i_element  (i_element),
        .o_stat     (w_stat),
        .o_used     (w_used),
        .o_status   (w_status),
        .o_value    (o_value),
        .o_last     (o_last),
        .o_count    (o_count)
    );

    assign o_status = w_status;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_command != pida_pkg::CMD_READ)) |=> o_valid)
        else $error("edit item gave no result");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pida_pkg::ST_OK)) |-> o_last)
        else $error("error result not marked last");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (w_used != $past(w_used))) |->
        (((w_used - $past(w_used)) == CW'(1)) || (($past(w_used) - w_used) == CW'(1))))
        else $error("entry count moved by more than one");
`endif

endmodule

// ===== design/pida_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_datapath
// Register chain of entries, entry count and the result register.
// ----------------------------------------------------------------------------
module pida_datapath #(
    parameter int  CAPACITY = 64,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int PW       = (CW > 7) ? CW : 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pida_pkg::t_dp_cmd                    i_cmd,
    input  logic [pida_pkg::POS_W-1:0]           i_position,
    input  logic signed [pida_pkg::VALUE_W-1:0]  i_element,
    output pida_pkg::t_dp_stat                   o_stat,
    output logic [CW-1:0]                        o_used,
    output pida_pkg::t_status                    o_status,
    output logic signed [pida_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_last,
    output logic [pida_pkg::COUNT_W-1:0]         o_count
);

    logic signed [pida_pkg::VALUE_W-1:0] r_entries [CAPACITY];
    logic signed [pida_pkg::VALUE_W-1:0] w_prev    [CAPACITY];
    logic signed [pida_pkg::VALUE_W-1:0] w_next    [CAPACITY];
    logic signed [pida_pkg::VALUE_W-1:0] w_d       [CAPACITY];
    logic [CAPACITY-1:0]                 w_we;

    logic [CW-1:0]                       r_used;
    logic [CW-1:0]                       n_used;
    logic [PW-1:0]                       w_pos;
    logic [PW-1:0]                       w_used;
    logic [CW+pida_pkg::COUNT_W-1:0]     w_cnt_ext;

    pida_pkg::t_status                   r_status;
    logic signed [pida_pkg::VALUE_W-1:0] r_value;
    logic                                r_last;
    logic [pida_pkg::COUNT_W-1:0]        r_count;

    assign w_pos  = PW'(i_position);
    assign w_used = PW'(r_used);

    // neighbor taps of the chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign w_prev[g] = r_entries[g];
        end else begin : g_rest
            assign w_prev[g] = r_entries[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next[g] = r_entries[g];
        end else begin : g_mid
            assign w_next[g] = r_entries[g+1];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_we[i] = 1'b0;
            w_d[i]  = i_element;
            case (i_cmd.op)
                pida_pkg::OP_APPEND: begin
                    w_we[i] = (w_used == PW'(i));
                end
                pida_pkg::OP_INSERT: begin
                    if (w_pos == PW'(i)) begin
                        w_we[i] = 1'b1;
                    end else if (w_pos < PW'(i)) begin
                        w_we[i] = 1'b1;
                        w_d[i]  = w_prev[i];
                    end
                end
                pida_pkg::OP_DELETE: begin
                    if (w_pos <= PW'(i)) begin
                        w_we[i] = 1'b1;
                        w_d[i]  = w_next[i];
                    end
                end
                pida_pkg::OP_ROTATE: begin
                    // rotate the stored part down by one, head wraps to the tail
                    if (PW'(i + 1) == w_used) begin
                        w_we[i] = 1'b1;
                        w_d[i]  = r_entries[0];
                    end else if (PW'(i) < w_used) begin
                        w_we[i] = 1'b1;
                        w_d[i]  = w_next[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_we[i]) begin
                r_entries[i] <= w_d[i];
            end
        end
    end

    always_comb begin
        case (i_cmd.op)
            pida_pkg::OP_APPEND,
            pida_pkg::OP_INSERT: n_used = r_used + CW'(1);
            pida_pkg::OP_DELETE: n_used = r_used - CW'(1);
            default:             n_used = r_used;
        endcase
    end

    assign w_cnt_ext = {{pida_pkg::COUNT_W{1'b0}}, n_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.status;
            r_value  <= i_cmd.from_head ? r_entries[0] : '0;
            r_last   <= i_cmd.last;
            r_count  <= w_cnt_ext[pida_pkg::COUNT_W-1:0];
        end
    end

    assign o_stat.full  = (r_used == CW'(CAPACITY));
    assign o_stat.empty = (r_used == '0);
    assign o_used       = r_used;
    assign o_status     = r_status;
    assign o_value      = r_value;
    assign o_last       = r_last;
    assign o_count      = r_count;

endmodule

// ===== design/pida_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_ctrl
// Command decode, read-out sequencing and result handshake.
// ----------------------------------------------------------------------------
module pida_ctrl #(
    parameter int  CAPACITY = 64,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int PW       = (CW > 7) ? CW : 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [1:0]                  i_command,
    input  logic [pida_pkg::POS_W-1:0]  i_position,
    input  logic                        i_stall,
    input  pida_pkg::t_dp_stat          i_stat,
    input  logic [CW-1:0]               i_used,
    output logic                        o_stall,
    output logic                        o_valid,
    output pida_pkg::t_dp_cmd           o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     n_idx;
    logic              r_out_valid;
    logic              w_out_free;
    logic              w_emit;
    logic [PW-1:0]     w_pos;
    logic [PW-1:0]     w_used;
    logic [PW-1:0]     w_idx;
    logic [PW-1:0]     w_last_idx;
    pida_pkg::t_dp_cmd w_cmd;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_pos      = PW'(i_position);
    assign w_used     = PW'(i_used);
    assign w_idx      = PW'(r_idx);
    assign w_emit     = (w_idx < PW'(pida_pkg::MAX_RESULTS));
    assign w_last_idx = (w_used > PW'(pida_pkg::MAX_RESULTS)) ?
                        PW'(pida_pkg::MAX_RESULTS - 1) : (w_used - PW'(1));

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        w_cmd.op        = pida_pkg::OP_NONE;
        w_cmd.load_out  = 1'b0;
        w_cmd.status    = pida_pkg::ST_OK;
        w_cmd.last      = 1'b1;
        w_cmd.from_head = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && w_out_free) begin
                    unique case (pida_pkg::t_cmd'(i_command))
                        pida_pkg::CMD_APPEND: begin
                            w_cmd.load_out = 1'b1;
                            if (i_stat.full) begin
                                w_cmd.status = pida_pkg::ST_FULL;
                            end else begin
                                w_cmd.op = pida_pkg::OP_APPEND;
                            end
                        end
                        pida_pkg::CMD_INSERT: begin
                            w_cmd.load_out = 1'b1;
                            if (i_stat.full) begin
                                w_cmd.status = pida_pkg::ST_FULL;
                            end else if (w_pos > w_used) begin
                                w_cmd.status = pida_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = pida_pkg::OP_INSERT;
                            end
                        end
                        pida_pkg::CMD_DELETE: begin
                            w_cmd.load_out = 1'b1;
                            if (i_stat.empty) begin
                                w_cmd.status = pida_pkg::ST_EMPTY;
                            end else if (w_pos >= w_used) begin
                                w_cmd.status = pida_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = pida_pkg::OP_DELETE;
                            end
                        end
                        pida_pkg::CMD_READ: begin
                            if (i_stat.empty) begin
                                w_cmd.load_out = 1'b1;
                                w_cmd.status   = pida_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                                n_idx   = '0;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // past the result limit the chain keeps rotating without output
                if (!w_emit || w_out_free) begin
                    w_cmd.op        = pida_pkg::OP_ROTATE;
                    w_cmd.load_out  = w_emit;
                    w_cmd.from_head = 1'b1;
                    w_cmd.last      = (w_idx == w_last_idx);
                    if (w_idx == w_used - PW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = !((r_state == S_IDLE) && w_out_free);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

endmodule
